/* hdl/vsa_pkg.sv */
// Package for the voice steal allocator: channel payload structs, voice
// table entry layout, per-voice evaluation result and fixed constants.
// No dependencies.
package vsa_pkg;

   localparam int ENTITY_W      = 16;
   localparam int SLOT_W        = 4;
   localparam int NOW_W         = 31;
   localparam int LENGTH_W      = 24;
   localparam int END_W         = 32;
   localparam int LEFT_W        = END_W + 1;
   localparam int VOICE_INDEX_W = 3;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // Request modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STOP  = 1'b1;

   // Slot codes with a special meaning
   localparam logic [SLOT_W-1:0] SLOT_NONE = 4'h0;
   localparam logic [SLOT_W-1:0] SLOT_ANY  = 4'hF;

   // Register byte addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_PLAYER_ENTITY = 3'd0;

   localparam logic [ENTITY_W-1:0] PLAYER_ENTITY_RESET = 16'd1;

   // Starting value of the least-time-left search
   localparam logic signed [LEFT_W-1:0] LIFE_START = 33'sh0_7fff_ffff;

   typedef struct packed {
      logic                       mode;
      logic [ENTITY_W-1:0]        requester_entity;
      logic signed [SLOT_W-1:0]   requester_slot;
      logic [NOW_W-1:0]           current_time;
      logic [LENGTH_W-1:0]        sound_length;
   } req_type;

   typedef struct packed {
      logic                       granted;
      logic [VOICE_INDEX_W-1:0]   voice_index;
   } rsp_type;

   typedef struct packed {
      logic [ENTITY_W-1:0] owner;
      logic [SLOT_W-1:0]   slot;
      logic [END_W-1:0]    end_time;
   } voice_entry_type;

   typedef struct packed {
      logic                     hit;
      logic                     less;
      logic signed [LEFT_W-1:0] left;
   } eval_type;

endpackage

/* hdl/vsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsa_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/vsa_voice_eval.sv */
// Shared compare and subtract unit: judges one voice against the request.
// Depends on vsa_pkg.
module vsa_voice_eval
   import vsa_pkg::*;
(
   input  voice_entry_type           entry,
   input  logic                      active,
   input  req_type                   req,
   input  logic [ENTITY_W-1:0]       player_entity,
   input  logic signed [LEFT_W-1:0]  least,
   output eval_type                  result
);

   logic [SLOT_W-1:0] req_slot;
   logic              owner_eq;
   logic              start_hit;
   logic              stop_hit;
   logic              protect;

   assign req_slot  = req.requester_slot;
   assign owner_eq  = (entry.owner == req.requester_entity);
   assign start_hit = (req_slot != SLOT_NONE) && owner_eq &&
                      ((entry.slot == req_slot) || (req_slot == SLOT_ANY));
   assign stop_hit  = owner_eq && (entry.slot == req_slot);
   // Player voices stay untouched by other entities while they sound
   assign protect   = active && (entry.owner == player_entity) &&
                      (req.requester_entity != player_entity);

   always_comb begin
      result.left = $signed({1'b0, entry.end_time}) -
                    $signed({{(LEFT_W-NOW_W){1'b0}}, req.current_time});
      if (req.mode == MODE_STOP) begin
         result.hit  = stop_hit;
         result.less = 1'b0;
      end else begin
         result.hit  = start_hit;
         result.less = !protect && (result.left < least);
      end
   end

endmodule

/* hdl/voice_steal_allocator.sv */
// Top level of the voice steal allocator: sequencer, register port, voice
// table RAM and result register. Depends on vsa_pkg, vsa_ram and
// vsa_voice_eval.
//
// Usage: a request transfer on req_* carries a start (mode 0) or a stop
// (mode 1). The block then scans the voice table one voice per cycle
// through the single RAM read port and the shared compare unit. A start
// takes the first voice of the same entity and slot, else the voice with
// the least time left; a stop takes the first exact entity/slot match.
// Exactly one result transfer follows on rsp_* for every request.
// A scan ends early at a hit, else after the last voice; the post state
// then loads the result register. The request side is stalled until the
// block returns to idle after the post state, so a new request is taken
// only once the previous one has loaded its result. The result sits in an
// output register; while rsp_stall holds it the block finishes the next
// request's scan and waits with its table update and result until the register frees up.
// Reset clears all voices (valid bits in flip-flops, no clearing pass),
// sets player_entity to 1 and empties the result register.
// player_entity is written at byte address 0 of the register port.
module voice_steal_allocator
   import vsa_pkg::*;
#(
   parameter int VOICE_COUNT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int IDX_W = $clog2(VOICE_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_POST = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   req_ff;
   logic [ENTITY_W-1:0]       player_ff;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic signed [LEFT_W-1:0]  least_ff, least_in;
   logic                      best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic [VOICE_COUNT-1:0]    valid_ff;
   logic [VOICE_COUNT-1:0]    active_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff;

   logic                      req_take;
   logic                      rsp_free;
   logic                      post_done;
   logic                      tbl_wr;
   voice_entry_type           tbl_wdata;
   logic [IDX_W-1:0]          tbl_raddr;
   voice_entry_type           tbl_rdata;
   voice_entry_type           cur_entry;
   eval_type                  eval;
   logic [END_W-1:0]          new_end;
   logic [IDX_W+VOICE_INDEX_W-1:0] idx_ext;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign post_done = (state_ff == S_POST) && rsp_free;

   // Register port: one register, zero-wait
   assign pready = 1'b1;
   always_comb begin
      if (paddr == ADDR_PLAYER_ENTITY) begin
         prdata = {{(CSR_DATA_W-ENTITY_W){1'b0}}, player_ff};
      end else begin
         prdata = '0;
      end
   end

   // Voice table: owner, slot and end time in RAM
   // Address ahead by one during the scan so data lines up with idx_ff.
   always_comb begin
      case (state_ff)
         S_SCAN:  tbl_raddr = idx_ff + IDX_W'(1);
         default: tbl_raddr = '0;
      endcase
   end

   assign new_end = (req_ff.mode == MODE_STOP) ? '0 :
                    ({1'b0, req_ff.current_time} +
                     {{(END_W-LENGTH_W){1'b0}}, req_ff.sound_length});
   assign tbl_wr    = post_done && best_valid_ff;
   assign tbl_wdata = '{owner:    req_ff.requester_entity,
                        slot:     req_ff.requester_slot,
                        end_time: new_end};

   vsa_ram #(
      .WIDTH ($bits(voice_entry_type)),
      .DEPTH (VOICE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (best_idx_ff),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   // Never-written voices read as cleared
   assign cur_entry = valid_ff[idx_ff] ? tbl_rdata : '0;

   vsa_voice_eval u_eval (
      .entry         (cur_entry),
      .active        (active_ff[idx_ff]),
      .req           (req_ff),
      .player_entity (player_ff),
      .least         (least_ff),
      .result        (eval)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      least_in      = least_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in      = S_SCAN;
               idx_in        = '0;
               least_in      = LIFE_START;
               best_valid_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (eval.hit) begin
               // Exact owner match: take it and end the scan
               best_valid_in = 1'b1;
               best_idx_in   = idx_ff;
               state_in      = S_POST;
            end else begin
               if (eval.less) begin
                  least_in      = eval.left;
                  best_valid_in = 1'b1;
                  best_idx_in   = idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_POST;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_POST: begin
            // Hold until the result register is free
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (post_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign idx_ext = {{VOICE_INDEX_W{1'b0}}, best_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         player_ff     <= PLAYER_ENTITY_RESET;
         valid_ff      <= '0;
         active_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_valid_ff <= best_valid_in;
         if (psel && penable && pwrite && pready && (paddr == ADDR_PLAYER_ENTITY)) begin
            player_ff <= pwdata[ENTITY_W-1:0];
         end
         if (tbl_wr) begin
            valid_ff[best_idx_ff]  <= 1'b1;
            active_ff[best_idx_ff] <= (req_ff.mode == MODE_START);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      least_ff    <= least_in;
      best_idx_ff <= best_idx_in;
      if (req_take) begin
         req_ff <= req_data;
      end
      if (post_done) begin
         rsp_data_ff.granted     <= best_valid_ff;
         rsp_data_ff.voice_index <= best_valid_ff ? idx_ext[VOICE_INDEX_W-1:0] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sim/tb_top.sv */
// Self-checking bench for voice_steal_allocator: drives start/stop requests,
// predicts grants from its own copy of the voice table, checks each result.
// Depends on vsa_pkg and the voice_steal_allocator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vsa_pkg::*;

   localparam int VOICES      = 8;
   localparam int CLK_HALF    = 6;
   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD   = 300;
   localparam int PHASE_ITEMS = 300;
   localparam int DRAIN_WAIT  = 20;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Bench-side copy of the voice table and the protected entity
   logic [ENTITY_W-1:0] tbl_owner  [VOICES];
   logic [SLOT_W-1:0]   tbl_slot   [VOICES];
   logic [END_W-1:0]    tbl_end    [VOICES];
   logic                tbl_active [VOICES];
   logic [ENTITY_W-1:0] player_id;

   req_type pending_reqs[$];   // requests not yet offered
   rsp_type grant_queue[$];    // predicted results, oldest first
   rsp_type grant_due;

   logic [ENTITY_W+SLOT_W-1:0] recent_keys[$];  // entity/slot pairs seen on start
   logic [NOW_W-1:0]           stamp = '0;      // running time for well-formed traffic

   int   mismatches   = 0;
   int   quiet_cycles = 0;
   int   req_gap      = 0;
   int   req_burst    = 0;
   int   rsp_wait     = 0;
   int   rsp_burst    = 0;
   int   hold_left    = 0;
   int   holds_asked  = 0;
   int   holds_done   = 0;
   logic req_sent     = 1'b0;
   logic rsp_sent     = 1'b0;

   voice_steal_allocator #(
      .VOICE_COUNT (VOICES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #(CLK_HALF) clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void clear_table();
      for (int i = 0; i < VOICES; i++) begin
         tbl_owner[i]  = '0;
         tbl_slot[i]   = '0;
         tbl_end[i]    = '0;
         tbl_active[i] = 1'b0;
      end
      player_id = PLAYER_ENTITY_RESET;
   endfunction

   // Work out the grant for one request and apply it to the table copy.
   function automatic rsp_type allocate_voice(input req_type item);
      rsp_type             grant;
      int                  chosen;
      longint              least;
      longint              left;
      logic [ENTITY_W-1:0] ent;
      logic [SLOT_W-1:0]   slot;
      chosen = -1;
      least  = longint'(LIFE_START);
      ent    = item.requester_entity;
      slot   = item.requester_slot;
      if (item.mode == MODE_START) begin
         for (int i = 0; i < VOICES; i++) begin
            // same entity and slot reuses its voice at once
            if (slot != SLOT_NONE && tbl_owner[i] == ent &&
                (tbl_slot[i] == slot || slot == SLOT_ANY)) begin
               chosen = i;
               break;
            end
            // player's active voices are off limits to everyone else
            if (tbl_owner[i] == player_id && ent != player_id && tbl_active[i])
               continue;
            left = longint'(tbl_end[i]) - longint'(item.current_time);
            if (left < least) begin
               least  = left;
               chosen = i;
            end
         end
         if (chosen >= 0) begin
            tbl_owner[chosen]  = ent;
            tbl_slot[chosen]   = slot;
            tbl_end[chosen]    = {1'b0, item.current_time} + {8'b0, item.sound_length};
            tbl_active[chosen] = 1'b1;
         end
      end else begin
         // exact match on all slot bits, active mark ignored
         for (int i = 0; i < VOICES; i++) begin
            if (tbl_owner[i] == ent && tbl_slot[i] == slot) begin
               tbl_end[i]    = '0;
               tbl_active[i] = 1'b0;
               chosen        = i;
               break;
            end
         end
      end
      grant.granted     = (chosen >= 0);
      grant.voice_index = (chosen >= 0) ? VOICE_INDEX_W'(chosen) : '0;
      return grant;
   endfunction

   // Draw an idle count: mostly 0..11, with occasional runs of no idling.
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = $urandom_range(15, 60);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic req_type make_req(input logic mode, input int ent, input int slot,
                                        input int now, input int len);
      req_type item;
      item.mode             = mode;
      item.requester_entity = ENTITY_W'(ent);
      item.requester_slot   = SLOT_W'(slot);
      item.current_time     = NOW_W'(now);
      item.sound_length     = LENGTH_W'(len);
      return item;
   endfunction

   // Mostly well-formed traffic: a small entity pool, steadily rising time,
   // and stops aimed at entity/slot pairs that were started recently.
   function automatic req_type random_req(input logic [ENTITY_W-1:0] player);
      req_type item;
      int      roll;
      int      pos;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         item.requester_entity = ENTITY_W'($urandom_range(0, 5));
      else if (roll < 85)
         item.requester_entity = player;
      else
         item.requester_entity = ENTITY_W'($urandom());
      item.requester_slot = SLOT_W'(int'($urandom_range(0, 8)) - 1);
      item.mode = ($urandom_range(0, 99) < 30) ? MODE_STOP : MODE_START;

      if (item.mode == MODE_STOP && recent_keys.size() > 0 &&
          $urandom_range(0, 99) < 75) begin
         pos = $urandom_range(0, recent_keys.size() - 1);
         {item.requester_entity, item.requester_slot} = recent_keys[pos];
      end

      stamp = stamp + NOW_W'($urandom_range(0, 'h3ffff));
      if ($urandom_range(0, 99) < 8)
         item.current_time = NOW_W'($urandom());
      else
         item.current_time = stamp;

      roll = $urandom_range(0, 99);
      if (roll < 10)
         item.sound_length = LENGTH_W'($urandom());
      else if (roll < 15)
         item.sound_length = '0;
      else
         item.sound_length = LENGTH_W'($urandom_range(0, 'h7ffff));

      if (item.mode == MODE_START) begin
         recent_keys.push_back({item.requester_entity, item.requester_slot});
         if (recent_keys.size() > 16)
            void'(recent_keys.pop_front());
      end
      return item;
   endfunction

   // Write player_entity over the register port, then read it back.
   task automatic write_player(input logic [ENTITY_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_PLAYER_ENTITY;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      player_id = value;
      // go straight into the read setup; psel stays high
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(value))
         report_mismatch($sformatf("player_entity read 0x%0h, wrote 0x%0h", prdata, value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Wait until every request has been taken and every result has come back.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || grant_queue.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   // Request driver: present the next pending item, hold it until the
   // transfer, then stay quiet for the drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_sent) begin
         // hold the stalled payload
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         req_data  <= pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_gap   <= draw_wait(req_burst);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver: stall a drawn number of cycles after each transfer,
   // and hold off for a long stretch whenever the stimulus asks for it.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_sent)
            rsp_wait = draw_wait(rsp_burst);
         if (holds_done != holds_asked) begin
            hold_left  = LONG_HOLD;
            holds_done = holds_asked;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predict on each request transfer, check on each result transfer.
   always @(posedge clock) begin
      req_sent <= !reset && req_valid && !req_stall;
      rsp_sent <= !reset && rsp_valid && !rsp_stall;
      if (reset) begin
         clear_table();
      end else begin
         if (req_valid && !req_stall)
            grant_queue.push_back(allocate_voice(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (grant_queue.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: granted=%0b index=%0d",
                                         rsp_data.granted, rsp_data.voice_index));
            end else begin
               grant_due = grant_queue.pop_front();
               if (rsp_data.granted !== grant_due.granted)
                  report_mismatch($sformatf("granted %0b, predicted %0b",
                                            rsp_data.granted, grant_due.granted));
               if (rsp_data.voice_index !== grant_due.voice_index)
                  report_mismatch($sformatf("voice_index %0d, predicted %0d",
                                            rsp_data.voice_index, grant_due.voice_index));
            end
         end
      end
   end

   // Watchdog: give up once nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [ENTITY_W-1:0] settings[4];
      settings[0] = 16'h0000;
      settings[1] = 16'hffff;
      settings[2] = ENTITY_W'($urandom());
      settings[3] = PLAYER_ENTITY_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, player_entity at its reset value.
      // An untouched table has owner 0 slot 0 in voice 0, so this stop hits.
      pending_reqs.push_back(make_req(MODE_STOP, 0, 0, 'h7fffffff, 'hffffff));
      // Fill every voice with the player's sounds; slot 0 never overrides.
      for (int k = 0; k < VOICES; k++)
         pending_reqs.push_back(make_req(MODE_START, 1, 0, 'h7fffffff, k * 'h249249));
      // Another entity finds every voice protected.
      pending_reqs.push_back(make_req(MODE_START, 2, 1, 'h7fffffff, 5));
      // Time left is at or above the search ceiling everywhere: no voice eligible.
      pending_reqs.push_back(make_req(MODE_START, 1, 0, 0, 0));
      // Wildcard slot takes the first voice of the same entity.
      pending_reqs.push_back(make_req(MODE_START, 1, -1, 100, 'h123456));
      // Stops: wildcard stored as a slot, no match, then a plain match.
      pending_reqs.push_back(make_req(MODE_STOP, 1, -1, 0, 0));
      pending_reqs.push_back(make_req(MODE_STOP, 1, 3, 'h7fffffff, 'hffffff));
      pending_reqs.push_back(make_req(MODE_STOP, 1, 0, 0, 0));
      // Two freed voices tie on time left: the lower index wins.
      pending_reqs.push_back(make_req(MODE_START, 'hffff, 7, 0, 'hffffff));
      pending_reqs.push_back(make_req(MODE_START, 'hffff, 7, 'h7fffffff, 0));
      pending_reqs.push_back(make_req(MODE_START, 'hffff, 0, 0, 3));
      // The player itself may steal from its own voices.
      pending_reqs.push_back(make_req(MODE_START, 1, 2, 'h7fffffff, 1));
      pending_reqs.push_back(make_req(MODE_STOP, 'hffff, 7, 0, 0));
      pending_reqs.push_back(make_req(MODE_STOP, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_START, 0, 0, 0, 'hffffff));
      pending_reqs.push_back(make_req(MODE_STOP, 'hffff, 0, 'h7fffffff, 'hffffff));
      wait_idle();

      // Random part, one phase per player_entity setting.
      foreach (settings[p]) begin
         write_player(settings[p]);
         // In one phase let the receiver sit on its results while requests
         // keep coming, so the block backs up and stalls its input.
         if (p == 1)
            holds_asked++;
         for (int n = 0; n < PHASE_ITEMS; n++)
            pending_reqs.push_back(random_req(settings[p]));
         wait_idle();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (grant_queue.size() > 0)
         report_mismatch($sformatf("%0d results never arrived", grant_queue.size()));
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* voice_steal_allocator.f */
hdl/vsa_pkg.sv
hdl/vsa_ram.sv
hdl/vsa_voice_eval.sv
hdl/voice_steal_allocator.sv
sim/tb_top.sv
